// File: rtl/core/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int US_W          = 10;
  localparam int BIDX_W        = $clog2(BITS_PER_BYTE);
  localparam int CFG_IDX_W     = 3;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TAIL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd7;

  // Register reset values, microseconds
  localparam logic [US_W-1:0] DEF_RESET_LOW     = 10'd960;
  localparam logic [US_W-1:0] DEF_PRESENCE_WAIT = 10'd70;
  localparam logic [US_W-1:0] DEF_PRESENCE_TAIL = 10'd420;
  localparam logic [US_W-1:0] DEF_WRITE_ONE_LOW = 10'd13;
  localparam logic [US_W-1:0] DEF_WRITE_ONE_HI  = 10'd60;
  localparam logic [US_W-1:0] DEF_WRITE_ZERO_LO = 10'd60;
  localparam logic [US_W-1:0] DEF_READ_LOW      = 10'd2;
  localparam logic [US_W-1:0] DEF_READ_SAMPLE   = 10'd10;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_W_REC    = 4'd4,
    PH_W_LOW    = 4'd5,
    PH_W_HIGH   = 4'd6,
    PH_R_LOW    = 4'd7,
    PH_R_WAIT   = 4'd8,
    PH_R_TAIL   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [US_W-1:0] reset_low_us;
    logic [US_W-1:0] presence_wait_us;
    logic [US_W-1:0] presence_tail_us;
    logic [US_W-1:0] write_one_low_us;
    logic [US_W-1:0] write_one_high_us;
    logic [US_W-1:0] write_zero_low_us;
    logic [US_W-1:0] read_low_us;
    logic [US_W-1:0] read_sample_us;
  } cfg_t;

  typedef struct packed {
    phase_t                     phase;
    logic [US_W-1:0]            tick_count;
    logic [BIDX_W-1:0]          bit_index;
    logic [BITS_PER_BYTE-1:0]   shift_reg;
    logic                       presence_seen;
    logic [BITS_PER_BYTE-1:0]   rx_last;
  } state_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [BITS_PER_BYTE-1:0] tx_byte;
    logic                     line_in;
  } item_t;

  typedef struct packed {
    logic                     drive_low;
    logic                     busy_res;
    logic                     done_res;
    logic                     presence;
    logic [BITS_PER_BYTE-1:0] rx_byte;
  } result_t;

endpackage

// File: rtl/core/owbm_if.sv
// Valid/ready channel interfaces for items in and results out.
`timescale 1ns / 1ps

interface owbm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic       line_in;

  modport source (output valid, kind, tx_byte, line_in, input ready);
  modport sink   (input valid, kind, tx_byte, line_in, output ready);
endinterface

interface owbm_result_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] rx_byte;

  modport source (output valid, drive_low, busy_res, done_res, presence, rx_byte,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, rx_byte,
                  output ready);
endinterface

// File: rtl/core/owbm_cfg_regs.sv
// Timing configuration registers, written by index.
`timescale 1ns / 1ps

module owbm_cfg_regs
  import owbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [US_W-1:0]      cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us      <= DEF_RESET_LOW;
      cfg.presence_wait_us  <= DEF_PRESENCE_WAIT;
      cfg.presence_tail_us  <= DEF_PRESENCE_TAIL;
      cfg.write_one_low_us  <= DEF_WRITE_ONE_LOW;
      cfg.write_one_high_us <= DEF_WRITE_ONE_HI;
      cfg.write_zero_low_us <= DEF_WRITE_ZERO_LO;
      cfg.read_low_us       <= DEF_READ_LOW;
      cfg.read_sample_us    <= DEF_READ_SAMPLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:     cfg.reset_low_us      <= cfg_data;
        REG_PRESENCE_WAIT: cfg.presence_wait_us  <= cfg_data;
        REG_PRESENCE_TAIL: cfg.presence_tail_us  <= cfg_data;
        REG_WRITE_ONE_LOW: cfg.write_one_low_us  <= cfg_data;
        REG_WRITE_ONE_HI:  cfg.write_one_high_us <= cfg_data;
        REG_WRITE_ZERO_LO: cfg.write_zero_low_us <= cfg_data;
        REG_READ_LOW:      cfg.read_low_us       <= cfg_data;
        REG_READ_SAMPLE:   cfg.read_sample_us    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/owbm_step.sv
// Next-state and result logic for one item.
`timescale 1ns / 1ps

module owbm_step
  import owbm_pkg::*;
#(
  parameter int SLOT_RECOVERY_US = 2,
  parameter int READ_TAIL_US     = 50
) (
  input  state_t  st,
  input  cfg_t    cfg,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  function automatic logic [US_W-1:0] at_least_one(input logic [US_W-1:0] v);
    return (v == '0) ? US_W'(1) : v;
  endfunction

  logic [US_W-1:0] tick_inc;
  logic [US_W-1:0] len;
  logic            last_bit;
  logic            done;

  assign tick_inc = st.tick_count + US_W'(1);
  assign last_bit = (st.bit_index == BIDX_W'(BITS_PER_BYTE - 1));

  always_comb begin
    case (st.phase)
      PH_RST_LOW:  len = at_least_one(cfg.reset_low_us);
      PH_RST_WAIT: len = at_least_one(cfg.presence_wait_us);
      PH_RST_TAIL: len = cfg.presence_tail_us;
      PH_W_REC:    len = US_W'(SLOT_RECOVERY_US);
      PH_W_LOW:    len = at_least_one(st.shift_reg[0] ? cfg.write_one_low_us
                                                      : cfg.write_zero_low_us);
      PH_W_HIGH:   len = cfg.write_one_high_us;
      PH_R_LOW:    len = at_least_one(cfg.read_low_us);
      PH_R_WAIT:   len = at_least_one(cfg.read_sample_us);
      PH_R_TAIL:   len = US_W'(READ_TAIL_US);
      default:     len = US_W'(1);
    endcase
  end

  always_comb begin
    st_next = st;
    done    = 1'b0;
    if (item.kind != KIND_TICK) begin
      // starts are ignored while busy
      if (st.phase == PH_IDLE) begin
        st_next.bit_index  = '0;
        st_next.tick_count = '0;
        case (item.kind)
          KIND_RESET: st_next.phase = PH_RST_LOW;
          KIND_WRITE: begin
            st_next.shift_reg = item.tx_byte;
            st_next.phase     = PH_W_REC;
          end
          default: begin
            st_next.shift_reg = '0;
            st_next.phase     = PH_R_LOW;
          end
        endcase
      end
    end else if (st.phase != PH_IDLE) begin
      st_next.tick_count = tick_inc;
      if (tick_inc >= len) begin
        st_next.tick_count = '0;
        case (st.phase)
          PH_RST_LOW: st_next.phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            st_next.presence_seen = ~item.line_in;
            if (!item.line_in && cfg.presence_tail_us != '0) begin
              st_next.phase = PH_RST_TAIL;
            end else begin
              done = 1'b1;
            end
          end
          PH_W_REC: st_next.phase = PH_W_LOW;
          PH_W_LOW, PH_W_HIGH: begin
            if (st.phase == PH_W_LOW && st.shift_reg[0] &&
                cfg.write_one_high_us != '0) begin
              st_next.phase = PH_W_HIGH;
            end else if (last_bit) begin
              done = 1'b1;
            end else begin
              st_next.bit_index = st.bit_index + BIDX_W'(1);
              st_next.shift_reg = st.shift_reg >> 1;
              st_next.phase     = PH_W_REC;
            end
          end
          PH_R_LOW: st_next.phase = PH_R_WAIT;
          PH_R_WAIT: begin
            st_next.shift_reg = {item.line_in, st.shift_reg[BITS_PER_BYTE-1:1]};
            st_next.phase     = PH_R_TAIL;
          end
          PH_R_TAIL: begin
            if (last_bit) begin
              st_next.rx_last = st.shift_reg;
              done            = 1'b1;
            end else begin
              st_next.bit_index = st.bit_index + BIDX_W'(1);
              st_next.phase     = PH_R_LOW;
            end
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          st_next.phase = PH_IDLE;
        end
      end
    end
  end

  assign res.drive_low = (st_next.phase == PH_RST_LOW) || (st_next.phase == PH_W_LOW) ||
                         (st_next.phase == PH_R_LOW);
  assign res.busy_res  = (st_next.phase != PH_IDLE);
  assign res.done_res  = done;
  assign res.presence  = st_next.presence_seen;
  assign res.rx_byte   = st_next.rx_last;

endmodule

// File: rtl/core/one_wire_bus_master.sv
// Top level of the one-wire bus master: state, result register and handshakes.
`timescale 1ns / 1ps
// Result: registered at its item's transfer and offered in the cycle after it.
// Throughput: one item per cycle unless a held result stalls items; the only
//   loop is the phase/tick state update, which closes through owbm_step.
// Reset (rst, synchronous): bus idle, counters cleared, presence and received
//   byte zero, timing registers back to their defaults, no result pending.

module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int SLOT_RECOVERY_US = 2,   // released gap before each write slot
  parameter int READ_TAIL_US     = 50   // released time after each read sample
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [US_W-1:0]      cfg_data,
  owbm_item_if.sink            item,
  owbm_result_if.source        result
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item_d;
  result_t res_next;
  result_t res_q;
  logic    res_valid;
  logic    item_xfer;

  owbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign item_d = '{kind: item.kind, tx_byte: item.tx_byte, line_in: item.line_in};

  owbm_step #(
    .SLOT_RECOVERY_US (SLOT_RECOVERY_US),
    .READ_TAIL_US     (READ_TAIL_US)
  ) u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item_d),
    .st_next (st_next),
    .res     (res_next)
  );

  // Take a new item whenever the result register is empty or being drained.
  assign item.ready = !res_valid || result.ready;
  assign item_xfer  = item.valid && item.ready;

  // Bus state advances only on an item transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_IDLE;
      st.tick_count    <= '0;
      st.bit_index     <= '0;
      st.shift_reg     <= '0;
      st.presence_seen <= 1'b0;
      st.rx_last       <= '0;
    end else if (item_xfer) begin
      st <= st_next;
    end
  end

  // Result register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_xfer) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      res_q <= res_next;
    end
  end

  assign result.valid     = res_valid;
  assign result.drive_low = res_q.drive_low;
  assign result.busy_res  = res_q.busy_res;
  assign result.done_res  = res_q.done_res;
  assign result.presence  = res_q.presence;
  assign result.rx_byte   = res_q.rx_byte;

`ifndef SYNTHESIS
  // A finishing result never reports the bus as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.done_res |-> !result.busy_res)
    else $error("done with busy set");

  // The master only pulls the line low inside an operation.
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.drive_low |-> result.busy_res)
    else $error("drive low while idle");

  // A start accepted while idle always launches an operation.
  a_start_launches: assert property (@(posedge clk) disable iff (rst)
    item_xfer && item.kind != KIND_TICK && st.phase == PH_IDLE
    |=> st.phase != PH_IDLE)
    else $error("start did not launch");

  // Ticks while idle leave the bus idle.
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    item_xfer && item.kind == KIND_TICK && st.phase == PH_IDLE
    |=> st.phase == PH_IDLE)
    else $error("idle tick changed phase");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking bench for the one-wire bus master: per-item status prediction and compare.
`timescale 1ns / 1ps

module testbench;
  import owbm_pkg::*;

  // Must match the parameters handed to u_dut below.
  localparam int SLOT_REC_US  = 2;
  localparam int READ_TAIL_US = 50;
  localparam int MAX_REPORTS  = 10;

  // How the bench models the bus level on tick items of an operation.
  typedef enum int {LINE_LOW, LINE_HIGH, LINE_RAND} line_mode_t;

  // Result-side back-pressure patterns.
  typedef enum int {RX_STEADY, RX_JITTER, RX_STARVED} stall_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [US_W-1:0]      cfg_data  = '0;

  owbm_item_if   item_ch ();
  owbm_result_if result_ch ();

  one_wire_bus_master #(
    .SLOT_RECOVERY_US(SLOT_REC_US),
    .READ_TAIL_US    (READ_TAIL_US)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  always #5 clk = ~clk;

  // Items waiting for the driver, and predicted status words waiting for the DUT.
  item_t       pending_items[$];
  result_t     expected_status[$];

  // Timing registers as the bench believes the DUT holds them.
  cfg_t        timing;
  // bus_model follows accepted items; bus_plan runs ahead while items are queued
  // so the generator knows when an operation finishes.
  state_t      bus_model;
  state_t      bus_plan;

  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned mismatches   = 0;
  bit          item_taken_flag = 1'b0;

  int          burst_left  = 1;
  int          gap_left    = 0;
  stall_mode_t stall_mode  = RX_STEADY;
  int          stall_cycle = 0;

  function automatic cfg_t make_timing(int rl, int pw, int pt, int w1l, int w1h, int w0l,
                                       int r_low, int r_smp);
    cfg_t t;
    t.reset_low_us      = US_W'(rl);
    t.presence_wait_us  = US_W'(pw);
    t.presence_tail_us  = US_W'(pt);
    t.write_one_low_us  = US_W'(w1l);
    t.write_one_high_us = US_W'(w1h);
    t.write_zero_low_us = US_W'(w0l);
    t.read_low_us       = US_W'(r_low);
    t.read_sample_us    = US_W'(r_smp);
    return t;
  endfunction

  // Registers whose legal range starts at 1 treat zero as a single tick.
  function automatic logic [US_W-1:0] at_least_one_us(logic [US_W-1:0] v);
    return (v == '0) ? US_W'(1) : v;
  endfunction

  // Ticks the current phase lasts under the given timing.
  function automatic logic [US_W-1:0] phase_len(state_t s, cfg_t c);
    case (s.phase)
      PH_RST_LOW:  return at_least_one_us(c.reset_low_us);
      PH_RST_WAIT: return at_least_one_us(c.presence_wait_us);
      PH_RST_TAIL: return c.presence_tail_us;
      PH_W_REC:    return US_W'(SLOT_REC_US);
      PH_W_LOW:    return at_least_one_us(s.shift_reg[0] ? c.write_one_low_us
                                                         : c.write_zero_low_us);
      PH_W_HIGH:   return c.write_one_high_us;
      PH_R_LOW:    return at_least_one_us(c.read_low_us);
      PH_R_WAIT:   return at_least_one_us(c.read_sample_us);
      PH_R_TAIL:   return US_W'(READ_TAIL_US);
      default:     return US_W'(1);
    endcase
  endfunction

  // One item through the bus master: updates state s and yields its status word.
  task automatic bus_step(inout state_t s, input cfg_t c, input item_t it,
                          output result_t r);
    logic fin;
    logic last_bit;
    fin = 1'b0;
    if (it.kind != KIND_TICK) begin
      // Start items are ignored while an operation runs.
      if (s.phase == PH_IDLE) begin
        s.bit_index  = '0;
        s.tick_count = '0;
        case (it.kind)
          KIND_RESET: s.phase = PH_RST_LOW;
          KIND_WRITE: begin
            s.shift_reg = it.tx_byte;
            s.phase     = PH_W_REC;
          end
          default: begin
            s.shift_reg = '0;
            s.phase     = PH_R_LOW;
          end
        endcase
      end
    end else if (s.phase != PH_IDLE) begin
      s.tick_count = s.tick_count + US_W'(1);
      if (s.tick_count >= phase_len(s, c)) begin
        last_bit     = (s.bit_index == BIDX_W'(BITS_PER_BYTE - 1));
        // Every phase change restarts the count, including the drop to idle.
        s.tick_count = '0;
        case (s.phase)
          PH_RST_LOW: s.phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            // Presence is a low line at the sample; no tail when the tail is zero.
            s.presence_seen = ~it.line_in;
            if (it.line_in || c.presence_tail_us == '0) fin = 1'b1;
            else s.phase = PH_RST_TAIL;
          end
          PH_RST_TAIL: fin = 1'b1;
          PH_W_REC:    s.phase = PH_W_LOW;
          PH_W_LOW, PH_W_HIGH: begin
            // A one bit gets its released part unless that part is zero long.
            if (s.phase == PH_W_LOW && s.shift_reg[0] && c.write_one_high_us != '0) begin
              s.phase = PH_W_HIGH;
            end else if (last_bit) begin
              fin = 1'b1;
            end else begin
              s.bit_index = s.bit_index + BIDX_W'(1);
              s.shift_reg = s.shift_reg >> 1;
              s.phase     = PH_W_REC;
            end
          end
          PH_R_LOW: s.phase = PH_R_WAIT;
          PH_R_WAIT: begin
            s.shift_reg = {it.line_in, s.shift_reg[BITS_PER_BYTE-1:1]};
            s.phase     = PH_R_TAIL;
          end
          PH_R_TAIL: begin
            if (last_bit) begin
              s.rx_last = s.shift_reg;
              fin       = 1'b1;
            end else begin
              s.bit_index = s.bit_index + BIDX_W'(1);
              s.phase     = PH_R_LOW;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) s.phase = PH_IDLE;
      end
    end
    r.drive_low = (s.phase == PH_RST_LOW) || (s.phase == PH_W_LOW) || (s.phase == PH_R_LOW);
    r.busy_res  = (s.phase != PH_IDLE);
    r.done_res  = fin;
    r.presence  = s.presence_seen;
    r.rx_byte   = s.rx_last;
  endtask

  // Queue one item; the planning copy advances so the generator tracks the bus.
  task automatic push_item(input logic [1:0] kind, input logic [7:0] tx, input logic line);
    item_t   it;
    result_t unused;
    it.kind    = kind;
    it.tx_byte = tx;
    it.line_in = line;
    bus_step(bus_plan, timing, it, unused);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // A whole operation: start item, then ticks until the plan says it is done.
  // Noisy operations may get idle ticks in front and stray starts while busy.
  task automatic queue_op(input logic [1:0] op, input logic [7:0] tx,
                          input line_mode_t mode, input bit noisy);
    logic line;
    if (noisy && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) push_item(KIND_TICK, 8'($urandom), 1'($urandom));
    end
    push_item(op, tx, 1'($urandom));
    while (bus_plan.phase != PH_IDLE) begin
      if (noisy && $urandom_range(0, 31) == 0) begin
        push_item(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      end
      case (mode)
        LINE_LOW:  line = 1'b0;
        LINE_HIGH: line = 1'b1;
        default:   line = 1'($urandom);
      endcase
      push_item(KIND_TICK, 8'($urandom), line);
    end
  endtask

  // Register write; only ever called while the bus master is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [US_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_RESET_LOW:     timing.reset_low_us      = val;
      REG_PRESENCE_WAIT: timing.presence_wait_us  = val;
      REG_PRESENCE_TAIL: timing.presence_tail_us  = val;
      REG_WRITE_ONE_LOW: timing.write_one_low_us  = val;
      REG_WRITE_ONE_HI:  timing.write_one_high_us = val;
      REG_WRITE_ZERO_LO: timing.write_zero_low_us = val;
      REG_READ_LOW:      timing.read_low_us       = val;
      REG_READ_SAMPLE:   timing.read_sample_us    = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input cfg_t t);
    write_reg(REG_RESET_LOW,     t.reset_low_us);
    write_reg(REG_PRESENCE_WAIT, t.presence_wait_us);
    write_reg(REG_PRESENCE_TAIL, t.presence_tail_us);
    write_reg(REG_WRITE_ONE_LOW, t.write_one_low_us);
    write_reg(REG_WRITE_ONE_HI,  t.write_one_high_us);
    write_reg(REG_WRITE_ZERO_LO, t.write_zero_low_us);
    write_reg(REG_READ_LOW,      t.read_low_us);
    write_reg(REG_READ_SAMPLE,   t.read_sample_us);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender holds off until every queued item was taken and every status word
  // came back.
  task automatic wait_all_done();
    while (items_taken != items_queued || expected_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Item driver: changes on the falling edge, works in bursts with gaps.
  always @(negedge clk) begin : drive_items
    item_t nxt;
    logic  hold;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      // An offered item stays put until the monitor saw its transfer.
      hold            = item_ch.valid && !item_taken_flag;
      item_taken_flag = 1'b0;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          item_ch.valid   <= 1'b1;
          item_ch.kind    <= nxt.kind;
          item_ch.tx_byte <= nxt.tx_byte;
          item_ch.line_in <= nxt.line_in;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // Roughly a quarter of bursts run straight into the next one.
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: switches between steady, jittery and starved stretches.
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (stall_cycle == 0) begin
        stall_mode  = stall_mode_t'($urandom_range(0, 2));
        stall_cycle = $urandom_range(20, 80);
      end else begin
        stall_cycle--;
      end
      case (stall_mode)
        RX_STEADY: result_ch.ready <= 1'b1;
        RX_JITTER: result_ch.ready <= ($urandom_range(0, 3) != 0);
        default:   result_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Monitor: on the rising edge, check a result transfer against the oldest
  // prediction, then predict the status for an item transfer.
  always @(posedge clk) begin : watch_channels
    item_t   it;
    result_t got;
    result_t want;
    result_t pred;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.drive_low = result_ch.drive_low;
        got.busy_res  = result_ch.busy_res;
        got.done_res  = result_ch.done_res;
        got.presence  = result_ch.presence;
        got.rx_byte   = result_ch.rx_byte;
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: status transfer with nothing outstanding: drive=%b busy=%b done=%b",
                     $realtime, got.drive_low, got.busy_res, got.done_res);
        end else begin
          want = expected_status.pop_front();
          if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res || got.presence !== want.presence ||
              got.rx_byte !== want.rx_byte) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: status mismatch, exp drive=%b busy=%b done=%b pres=%b rx=%h",
                       $realtime, want.drive_low, want.busy_res, want.done_res,
                       want.presence, want.rx_byte);
              $display("    got drive=%b busy=%b done=%b pres=%b rx=%h",
                       got.drive_low, got.busy_res, got.done_res, got.presence, got.rx_byte);
            end
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        it.kind    = item_ch.kind;
        it.tx_byte = item_ch.tx_byte;
        it.line_in = item_ch.line_in;
        bus_step(bus_model, timing, it, pred);
        expected_status.push_back(pred);
        items_taken++;
        item_taken_flag = 1'b1;
      end
    end
  end

  initial begin : stimulus
    item_ch.valid   = 1'b0;
    item_ch.kind    = KIND_TICK;
    item_ch.tx_byte = '0;
    item_ch.line_in = 1'b1;
    result_ch.ready = 1'b0;
    timing    = make_timing(DEF_RESET_LOW, DEF_PRESENCE_WAIT, DEF_PRESENCE_TAIL,
                            DEF_WRITE_ONE_LOW, DEF_WRITE_ONE_HI, DEF_WRITE_ZERO_LO,
                            DEF_READ_LOW, DEF_READ_SAMPLE);
    bus_model = '0;
    bus_plan  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Out of reset: idle ticks show a released line, no presence, zero byte.
    push_item(KIND_TICK, 8'hFF, 1'b0);
    push_item(KIND_TICK, 8'h00, 1'b1);
    wait_all_done();

    // Minimal timing: no presence, presence with a zero tail, and an
    // all-one byte with the one-bit released part skipped.
    set_timing(make_timing(1, 1, 0, 1, 0, 1, 1, 1));
    queue_op(KIND_RESET, 8'h00, LINE_HIGH, 1'b0);
    queue_op(KIND_RESET, 8'h00, LINE_LOW, 1'b0);
    queue_op(KIND_WRITE, 8'hFF, LINE_RAND, 1'b0);
    wait_all_done();

    // Zero in the registers that count zero as one tick, short tail and
    // one-high times; mixed byte, then one read of random bits.
    // The fixed read tail makes the read the longest operation by far.
    set_timing(make_timing(0, 0, 2, 0, 2, 0, 0, 0));
    queue_op(KIND_RESET, 8'h00, LINE_LOW, 1'b0);
    queue_op(KIND_WRITE, 8'h5A, LINE_RAND, 1'b1);
    queue_op(KIND_READ, 8'hA5, LINE_RAND, 1'b1);
    wait_all_done();

    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, 1 ms: well above the slowest legal run of this stimulus.
  initial begin : watchdog
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/owbm_pkg.sv
rtl/core/owbm_if.sv
rtl/core/owbm_cfg_regs.sv
rtl/core/owbm_step.sv
rtl/core/one_wire_bus_master.sv
verif/testbench.sv
